FILE: hdl/lsepg_pkg.sv
// ----------------------------------------------------------------------------
// LED strip effect package
// Shared beat types, register indexes and the breathing table.
// ----------------------------------------------------------------------------
package lsepg_pkg;

    typedef struct packed {
        logic [5:0]  pixel_index;
        logic        frame_start;
        logic [31:0] random_word;
    } pix_req_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_pixel;
    } pix_rsp_t;

    localparam logic [2:0] REG_BASE_HUE   = 3'd0;
    localparam logic [2:0] REG_SATURATION = 3'd1;
    localparam logic [2:0] REG_BRIGHTNESS = 3'd2;
    localparam logic [2:0] REG_LIT_COUNT  = 3'd3;
    localparam logic [2:0] REG_EFFECT     = 3'd4;
    localparam logic [2:0] REG_ENABLE     = 3'd5;

    localparam logic [2:0] FX_SOLID   = 3'd0;
    localparam logic [2:0] FX_RAINBOW = 3'd1;
    localparam logic [2:0] FX_BREATHE = 3'd2;
    localparam logic [2:0] FX_CHASE   = 3'd3;
    localparam logic [2:0] FX_SPARKLE = 3'd4;

    // round(128*sin(k*pi/128)) for k = 0..64
    function automatic logic [7:0] quarter_sine(input logic [6:0] k);
        logic [7:0] q;
        case (k)
            7'd0: q = 8'd0;     7'd1: q = 8'd3;     7'd2: q = 8'd6;     7'd3: q = 8'd9;
            7'd4: q = 8'd13;    7'd5: q = 8'd16;    7'd6: q = 8'd19;    7'd7: q = 8'd22;
            7'd8: q = 8'd25;    7'd9: q = 8'd28;    7'd10: q = 8'd31;   7'd11: q = 8'd34;
            7'd12: q = 8'd37;   7'd13: q = 8'd40;   7'd14: q = 8'd43;   7'd15: q = 8'd46;
            7'd16: q = 8'd49;   7'd17: q = 8'd52;   7'd18: q = 8'd55;   7'd19: q = 8'd58;
            7'd20: q = 8'd60;   7'd21: q = 8'd63;   7'd22: q = 8'd66;   7'd23: q = 8'd68;
            7'd24: q = 8'd71;   7'd25: q = 8'd74;   7'd26: q = 8'd76;   7'd27: q = 8'd79;
            7'd28: q = 8'd81;   7'd29: q = 8'd84;   7'd30: q = 8'd86;   7'd31: q = 8'd88;
            7'd32: q = 8'd91;   7'd33: q = 8'd93;   7'd34: q = 8'd95;   7'd35: q = 8'd97;
            7'd36: q = 8'd99;   7'd37: q = 8'd101;  7'd38: q = 8'd103;  7'd39: q = 8'd105;
            7'd40: q = 8'd106;  7'd41: q = 8'd108;  7'd42: q = 8'd110;  7'd43: q = 8'd111;
            7'd44: q = 8'd113;  7'd45: q = 8'd114;  7'd46: q = 8'd116;  7'd47: q = 8'd117;
            7'd48: q = 8'd118;  7'd49: q = 8'd119;  7'd50: q = 8'd121;  7'd51: q = 8'd122;
            7'd52: q = 8'd122;  7'd53: q = 8'd123;  7'd54: q = 8'd124;  7'd55: q = 8'd125;
            7'd56: q = 8'd126;  7'd57: q = 8'd126;  7'd58: q = 8'd127;  7'd59: q = 8'd127;
            7'd60: q = 8'd127;  7'd61: q = 8'd128;  7'd62: q = 8'd128;  7'd63: q = 8'd128;
            default: q = 8'd128;
        endcase
        return q;
    endfunction

    function automatic logic [7:0] breath_factor(input logic [7:0] k);
        logic [6:0] half;
        logic [7:0] mag;
        logic [8:0] f;
        half = k[6:0];
        mag  = (half <= 7'd64) ? quarter_sine(half) : quarter_sine(7'd0 - half);
        f    = k[7] ? (9'd128 - {1'b0, mag}) : (9'd128 + {1'b0, mag});
        return f[8] ? 8'd255 : f[7:0];
    endfunction

endpackage

FILE: hdl/lsepg_divider.sv
// ----------------------------------------------------------------------------
// Shared restoring divider
// Unsigned 32 by 32 division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsepg_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);

    logic [31:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [32:0] shifted;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[31]};
        trial     = shifted - {1'b0, dvs_reg};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("divider done held");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy_reg) else $error("divider busy at done");
    a_cnt_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != 6'd0) else $error("divider count lost");
`endif

endmodule

FILE: hdl/led_strip_effect_pixel_generator.sv
// ----------------------------------------------------------------------------
// LED strip effect pixel generator
// One pixel request in, one RGB beat out, under a small sequencer.
// ----------------------------------------------------------------------------
// Usage: a request beat (pixel index, frame start flag, random word) is taken
// on in_valid/in_ready and the pixel colour comes back on out_valid/out_ready.
// One beat is in flight at a time: in_ready is high only while the sequencer
// is idle and no result is waiting.
// A request for a black pixel goes straight to the output register; a gray
// one (saturation zero) skips the HSV products, and the effects add their own
// steps. The two divisions by lit_count (rainbow spread and chase head) run
// on a shared restoring divider that holds the sequencer while it runs; the
// HSV products, the breathing level and the chase /10 share one 8x8
// multiplier, one step per cycle. With out_ready high the next request is
// taken once the result has been delivered. Reset returns the configuration
// registers to their defaults and clears the frame counter. When the receiver
// stalls, the result is held in the output register; no new request is taken
// until it is delivered. The user must let configuration writes (cfg_we,
// cfg_index, cfg_data) apply only when idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module led_strip_effect_pixel_generator #(
    parameter int NUM_LEDS = 60
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lsepg_pkg::pix_req_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lsepg_pkg::pix_rsp_t  out_data,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [8:0]           cfg_data
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_HUE   = 5'd1;  // base_hue mod 360
    localparam logic [4:0] S_RB1   = 5'd2;  // idx*360 / lit
    localparam logic [4:0] S_RB3   = 5'd4;  // sum mod 360
    localparam logic [4:0] S_CH2   = 5'd6;  // (fc / 3) mod lit
    localparam logic [4:0] S_SP    = 5'd7;  // rnd mod 20
    localparam logic [4:0] S_BR    = 5'd8;  // level multiply
    localparam logic [4:0] S_REG   = 5'd9;  // h / 60
    localparam logic [4:0] S_REM   = 5'd10; // rem*255 / 60
    localparam logic [4:0] S_M1    = 5'd11; // s*rem
    localparam logic [4:0] S_M2    = 5'd12; // s*(255-rem)
    localparam logic [4:0] S_M3    = 5'd13; // v*(255-s)
    localparam logic [4:0] S_M4    = 5'd14; // v*(255-a)
    localparam logic [4:0] S_M5    = 5'd15; // v*(255-b)
    localparam logic [4:0] S_MAP   = 5'd16;
    localparam logic [4:0] S_DIM0  = 5'd17;
    localparam logic [4:0] S_DIM1  = 5'd18;
    localparam logic [4:0] S_DIM2  = 5'd19;
    localparam logic [4:0] S_OUT   = 5'd20;
    localparam logic [4:0] S_WAIT  = 5'd21; // divider busy

    localparam logic [8:0] NUM_LEDS_W = 9'(NUM_LEDS);
    localparam logic [8:0] LAST_IDX   = 9'(NUM_LEDS - 1);
    // x / 10 = (x * 205) >> 11 for any 8-bit x
    localparam logic [7:0] DIV10_RECIP = 8'd205;

    logic [8:0] hue_cfg_reg;
    logic [7:0] sat_reg, bri_reg;
    logic [5:0] lit_reg;
    logic [2:0] fx_reg;
    logic       en_reg;
    logic [31:0] fc_reg;
    logic [8:0]  fcm_reg;   // fc mod 360
    logic [30:0] fc3q_reg;  // fc / 3
    logic [1:0]  fc3r_reg;  // fc mod 3

    logic [4:0] st_reg, st_next;
    lsepg_pkg::pix_req_t req_reg;
    lsepg_pkg::pix_rsp_t rsp_reg;
    logic        ov_reg;
    logic [8:0]  hue_reg, hue_next;
    logic [7:0]  v_reg, v_next;
    logic [2:0]  region_reg, region_next;
    logic [7:0]  rem_reg, rem_next;
    logic [7:0]  a_reg, a_next, b_reg, b_next;
    logic [7:0]  p_reg, p_next, q_reg, q_next, t_reg, t_next;
    logic [7:0]  c0_reg, c0_next, c1_reg, c1_next, c2_reg, c2_next;
    logic [31:0] tmp_reg, tmp_next;
    logic        dim_reg, dim_next;
    logic        div_rb_reg, div_rb_next;

    logic        take;
    logic        frame_step;
    logic [2:0]  hue_region;
    logic [5:0]  hue_off;
    logic [10:0] rb_red;
    logic [9:0]  rem_x17;
    logic [6:0]  nib_sum;
    logic [4:0]  fold1, fold2;
    logic        rnd_mod20_zero;

    logic        div_start;
    logic [31:0] div_a, div_b;
    logic        div_done;
    logic [31:0] div_q, div_r;
    logic [7:0]  mul_a, mul_b;
    logic [15:0] mul_p;

    lsepg_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
        .divisor(div_b), .done(div_done), .quotient(div_q), .remainder(div_r)
    );

    assign mul_p = mul_a * mul_b;
    assign in_ready = (st_reg == S_IDLE) && !ov_reg;
    assign take = in_valid && in_ready;
    assign frame_step = take && en_reg && in_data.frame_start;

    // 60-degree region and offset by compare and subtract
    always_comb
    begin
        if (hue_reg >= 9'd300)
        begin
            hue_region = 3'd5; hue_off = 6'(hue_reg - 9'd300);
        end
        else if (hue_reg >= 9'd240)
        begin
            hue_region = 3'd4; hue_off = 6'(hue_reg - 9'd240);
        end
        else if (hue_reg >= 9'd180)
        begin
            hue_region = 3'd3; hue_off = 6'(hue_reg - 9'd180);
        end
        else if (hue_reg >= 9'd120)
        begin
            hue_region = 3'd2; hue_off = 6'(hue_reg - 9'd120);
        end
        else if (hue_reg >= 9'd60)
        begin
            hue_region = 3'd1; hue_off = 6'(hue_reg - 9'd60);
        end
        else
        begin
            hue_region = 3'd0; hue_off = hue_reg[5:0];
        end
    end

    // rainbow sum is below 1080: at most two subtractions of 360
    always_comb
    begin
        if (tmp_reg[10:0] >= 11'd720)
            rb_red = tmp_reg[10:0] - 11'd720;
        else if (tmp_reg[10:0] >= 11'd360)
            rb_red = tmp_reg[10:0] - 11'd360;
        else
            rb_red = tmp_reg[10:0];
    end

    // rem*255/60 equals rem*17/4
    assign rem_x17 = {tmp_reg[5:0], 4'd0} + {4'd0, tmp_reg[5:0]};

    // 16 = 1 mod 5: fold the hex digits, then a value of 15 or less remains
    assign nib_sum = ({3'd0, req_reg.random_word[3:0]} + {3'd0, req_reg.random_word[7:4]})
                   + ({3'd0, req_reg.random_word[11:8]} + {3'd0, req_reg.random_word[15:12]})
                   + ({3'd0, req_reg.random_word[19:16]} + {3'd0, req_reg.random_word[23:20]})
                   + ({3'd0, req_reg.random_word[27:24]} + {3'd0, req_reg.random_word[31:28]});
    assign fold1 = {2'd0, nib_sum[6:4]} + {1'b0, nib_sum[3:0]};
    assign fold2 = {4'd0, fold1[4]} + {1'b0, fold1[3:0]};
    assign rnd_mod20_zero = (req_reg.random_word[1:0] == 2'd0)
                          && (fold2 == 5'd0 || fold2 == 5'd5 || fold2 == 5'd10
                              || fold2 == 5'd15);

    always_comb
    begin
        st_next = st_reg;
        hue_next = hue_reg; v_next = v_reg; region_next = region_reg;
        rem_next = rem_reg; a_next = a_reg; b_next = b_reg;
        p_next = p_reg; q_next = q_reg; t_next = t_reg;
        c0_next = c0_reg; c1_next = c1_reg; c2_next = c2_reg;
        tmp_next = tmp_reg; dim_next = dim_reg; div_rb_next = div_rb_reg;
        div_start = 1'b0; div_a = '0; div_b = 32'd1;
        mul_a = '0; mul_b = '0;
        case (st_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    c0_next = '0; c1_next = '0; c2_next = '0; dim_next = 1'b0;
                    tmp_next = (fc_reg + {31'd0, en_reg & in_data.frame_start}) * 32'd522;
                    st_next = S_OUT;
                    if (en_reg && {3'd0, in_data.pixel_index} < NUM_LEDS_W
                        && in_data.pixel_index < lit_reg
                        && fx_reg <= lsepg_pkg::FX_SPARKLE)
                        st_next = S_HUE;
                end
            end
            S_HUE:
            begin
                hue_next = (hue_cfg_reg >= 9'd360) ? hue_cfg_reg - 9'd360 : hue_cfg_reg;
                v_next = bri_reg;
                case (fx_reg)
                    lsepg_pkg::FX_RAINBOW: st_next = S_RB1;
                    lsepg_pkg::FX_BREATHE: st_next = S_BR;
                    lsepg_pkg::FX_CHASE:   st_next = S_CH2;
                    lsepg_pkg::FX_SPARKLE: st_next = S_SP;
                    default:               st_next = S_REG;
                endcase
            end
            S_WAIT:
            begin
                if (div_done)
                begin
                    if (div_rb_reg)
                    begin
                        tmp_next = {23'd0, hue_reg} + div_q + {23'd0, fcm_reg};
                        st_next = S_RB3;
                    end
                    else
                    begin
                        dim_next = div_r[5:0] != req_reg.pixel_index;
                        st_next = S_REG;
                    end
                end
            end
            S_RB1:
            begin
                div_start = 1'b1; div_a = {26'd0, req_reg.pixel_index} * 32'd360;
                div_b = {26'd0, lit_reg}; div_rb_next = 1'b1; st_next = S_WAIT;
            end
            S_RB3:
            begin
                hue_next = rb_red[8:0]; st_next = S_REG;
            end
            S_CH2:
            begin
                div_start = 1'b1; div_a = {1'b0, fc3q_reg}; div_b = {26'd0, lit_reg};
                div_rb_next = 1'b0; st_next = S_WAIT;
            end
            S_SP:
            begin
                dim_next = !rnd_mod20_zero; st_next = S_REG;
            end
            S_BR:
            begin
                // phase = fc*522 mod 2^16; only the low 16 bits of fc matter
                mul_a = bri_reg;
                mul_b = lsepg_pkg::breath_factor(tmp_reg[15:8]);
                v_next = mul_p[15:8]; st_next = S_REG;
            end
            S_REG:
            begin
                if (sat_reg == 8'd0)
                begin
                    c0_next = v_reg; c1_next = v_reg; c2_next = v_reg;
                    st_next = S_DIM0;
                end
                else
                begin
                    region_next = hue_region;
                    tmp_next = {26'd0, hue_off};
                    st_next = S_REM;
                end
            end
            S_REM:
            begin
                rem_next = rem_x17[9:2]; st_next = S_M1;
            end
            S_M1: begin mul_a = sat_reg; mul_b = rem_reg; a_next = mul_p[15:8]; st_next = S_M2; end
            S_M2:
            begin
                mul_a = sat_reg; mul_b = 8'd255 - rem_reg; b_next = mul_p[15:8]; st_next = S_M3;
            end
            S_M3:
            begin
                mul_a = v_reg; mul_b = 8'd255 - sat_reg; p_next = mul_p[15:8]; st_next = S_M4;
            end
            S_M4:
            begin
                mul_a = v_reg; mul_b = 8'd255 - a_reg; q_next = mul_p[15:8]; st_next = S_M5;
            end
            S_M5:
            begin
                mul_a = v_reg; mul_b = 8'd255 - b_reg; t_next = mul_p[15:8]; st_next = S_MAP;
            end
            S_MAP:
            begin
                case (region_reg)
                    3'd0: begin c0_next = v_reg; c1_next = t_reg; c2_next = p_reg; end
                    3'd1: begin c0_next = q_reg; c1_next = v_reg; c2_next = p_reg; end
                    3'd2: begin c0_next = p_reg; c1_next = v_reg; c2_next = t_reg; end
                    3'd3: begin c0_next = p_reg; c1_next = q_reg; c2_next = v_reg; end
                    3'd4: begin c0_next = t_reg; c1_next = p_reg; c2_next = v_reg; end
                    default: begin c0_next = v_reg; c1_next = p_reg; c2_next = q_reg; end
                endcase
                st_next = S_DIM0;
            end
            S_DIM0:
            begin
                st_next = S_OUT;
                if (dim_reg && fx_reg == lsepg_pkg::FX_SPARKLE)
                begin
                    c0_next = {3'd0, c0_reg[7:3]};
                    c1_next = {3'd0, c1_reg[7:3]};
                    c2_next = {3'd0, c2_reg[7:3]};
                end
                else if (dim_reg && fx_reg == lsepg_pkg::FX_CHASE)
                begin
                    mul_a = c0_reg; mul_b = DIV10_RECIP;
                    c0_next = {3'd0, mul_p[15:11]}; st_next = S_DIM1;
                end
            end
            S_DIM1:
            begin
                mul_a = c1_reg; mul_b = DIV10_RECIP;
                c1_next = {3'd0, mul_p[15:11]}; st_next = S_DIM2;
            end
            S_DIM2:
            begin
                mul_a = c2_reg; mul_b = DIV10_RECIP;
                c2_next = {3'd0, mul_p[15:11]}; st_next = S_OUT;
            end
            S_OUT: st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hue_cfg_reg <= 9'd0; sat_reg <= 8'd255; bri_reg <= 8'd128;
            lit_reg <= 6'd10; fx_reg <= lsepg_pkg::FX_SOLID; en_reg <= 1'b1;
            fc_reg <= '0; fcm_reg <= '0; fc3q_reg <= '0; fc3r_reg <= '0;
            st_reg <= S_IDLE; ov_reg <= 1'b0;
            div_rb_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next; div_rb_reg <= div_rb_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    lsepg_pkg::REG_BASE_HUE:   hue_cfg_reg <= cfg_data;
                    lsepg_pkg::REG_SATURATION: sat_reg <= cfg_data[7:0];
                    lsepg_pkg::REG_BRIGHTNESS: bri_reg <= cfg_data[7:0];
                    lsepg_pkg::REG_LIT_COUNT:  lit_reg <= cfg_data[5:0];
                    lsepg_pkg::REG_EFFECT:     fx_reg <= cfg_data[2:0];
                    lsepg_pkg::REG_ENABLE:     en_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (frame_step)
            begin
                fc_reg <= fc_reg + 32'd1;
                // the counter wraps to zero, which restarts both residues
                if (fc_reg == 32'hFFFF_FFFF)
                begin
                    fcm_reg <= '0; fc3q_reg <= '0; fc3r_reg <= '0;
                end
                else
                begin
                    fcm_reg <= (fcm_reg == 9'd359) ? 9'd0 : fcm_reg + 9'd1;
                    if (fc3r_reg == 2'd2)
                    begin
                        fc3r_reg <= 2'd0;
                        fc3q_reg <= fc3q_reg + 31'd1;
                    end
                    else
                        fc3r_reg <= fc3r_reg + 2'd1;
                end
            end
            if (st_reg == S_OUT)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == S_IDLE && take)
            req_reg <= in_data;
        if (st_reg == S_OUT)
        begin
            rsp_reg.red <= c0_reg; rsp_reg.green <= c1_reg; rsp_reg.blue <= c2_reg;
            rsp_reg.last_pixel <= {3'd0, req_reg.pixel_index} == LAST_IDX;
        end
        hue_reg <= hue_next; v_reg <= v_next; region_reg <= region_next;
        rem_reg <= rem_next; a_reg <= a_next; b_reg <= b_next;
        p_reg <= p_next; q_reg <= q_next; t_reg <= t_next;
        c0_reg <= c0_next; c1_reg <= c1_next; c2_reg <= c2_next;
        tmp_reg <= tmp_next; dim_reg <= dim_next;
    end

    assign out_valid = ov_reg;
    assign out_data  = rsp_reg;

`ifndef SYNTHESIS
    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg != S_IDLE |-> !in_ready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped");
    a_fc_step: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_valid && in_ready) |=> $stable(fc_reg)) else $error("frame count moved");
    a_fcm_range: assert property (@(posedge clk) disable iff (!rst_n)
        fcm_reg < 9'd360) else $error("frame residue out of range");
`endif

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// LED strip effect pixel generator testbench
// Drives pixel request beats through directed rows and random phases, predicts
// each colour beat from a local HSV/effect model and checks it field by field.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_LEDS = 60;
    localparam int STEP_PER_FRAME = 522;

    typedef struct {
        logic [5:0]          pixel_index;
        logic                frame_start;
        logic [31:0]         random_word;
        logic                has_expect;
        lsepg_pkg::pix_rsp_t expect_rsp;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    lsepg_pkg::pix_req_t in_data;
    logic        out_valid;
    logic        out_ready;
    lsepg_pkg::pix_rsp_t out_data;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [8:0]  cfg_data;

    // model copy of registers and state
    logic [8:0]  hue_reg;
    logic [7:0]  sat_reg;
    logic [7:0]  bright_reg;
    logic [5:0]  lit_reg;
    logic [2:0]  fx_reg;
    logic        enable_reg;
    logic [31:0] frame_cnt;

    lsepg_pkg::pix_rsp_t pending_pixels[$];
    int          error_count;
    int          checked_count;
    int          sent_count;
    bit          quiet_out;

    led_strip_effect_pixel_generator #(.NUM_LEDS(NUM_LEDS)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at pixel %0d: %s got %0d want %0d", checked_count, what, got, want);
        error_count++;
    endtask

    function automatic int sine_level(input int k);
        int tbl[65] = '{
              0,   3,   6,   9,  13,  16,  19,  22,  25,  28,  31,  34,  37,  40,  43,  46,
             49,  52,  55,  58,  60,  63,  66,  68,  71,  74,  76,  79,  81,  84,  86,  88,
             91,  93,  95,  97,  99, 101, 103, 105, 106, 108, 110, 111, 113, 114, 116, 117,
            118, 119, 121, 122, 122, 123, 124, 125, 126, 126, 127, 127, 127, 128, 128, 128,
            128};
        int half;
        int mag;
        int f;
        half = k & 127;
        mag = (half <= 64) ? tbl[half] : tbl[128 - half];
        f = (k < 128) ? 128 + mag : 128 - mag;
        return (f > 255) ? 255 : f;
    endfunction

    function automatic void hsv_color(input int h, input int s, input int v,
                                      output int r, output int g, output int b);
        int region;
        int rem;
        int p;
        int q;
        int t;
        if (s == 0)
        begin
            r = v; g = v; b = v;
            return;
        end
        region = h / 60;
        rem = ((h - region * 60) * 255) / 60;
        p = (v * (255 - s)) >> 8;
        q = (v * (255 - ((s * rem) >> 8))) >> 8;
        t = (v * (255 - ((s * (255 - rem)) >> 8))) >> 8;
        case (region)
            0: begin r = v; g = t; b = p; end
            1: begin r = q; g = v; b = p; end
            2: begin r = p; g = v; b = t; end
            3: begin r = p; g = q; b = v; end
            4: begin r = t; g = p; b = v; end
            default: begin r = v; g = p; b = q; end
        endcase
    endfunction

    // advance the frame counter and work out the colour of one request
    function automatic lsepg_pkg::pix_rsp_t predict_pixel(input lsepg_pkg::pix_req_t req);
        lsepg_pkg::pix_rsp_t rsp;
        int          hue;
        int          r;
        int          g;
        int          b;
        int          lvl;
        longint      sum;
        logic [31:0] phase;
        r = 0; g = 0; b = 0;
        hue = int'(hue_reg) % 360;
        if (enable_reg && req.frame_start)
            frame_cnt = frame_cnt + 32'd1;
        if (enable_reg && req.pixel_index < NUM_LEDS && req.pixel_index < lit_reg)
        begin
            case (fx_reg)
                lsepg_pkg::FX_SOLID: hsv_color(hue, sat_reg, bright_reg, r, g, b);
                lsepg_pkg::FX_RAINBOW:
                begin
                    sum = longint'(hue) + longint'((int'(req.pixel_index) * 360) / int'(lit_reg))
                        + longint'(frame_cnt);
                    hsv_color(int'(sum % 360), sat_reg, bright_reg, r, g, b);
                end
                lsepg_pkg::FX_BREATHE:
                begin
                    phase = frame_cnt * 32'(STEP_PER_FRAME);
                    lvl = (int'(bright_reg) * sine_level(int'(phase[15:8]))) >> 8;
                    hsv_color(hue, sat_reg, lvl, r, g, b);
                end
                lsepg_pkg::FX_CHASE:
                begin
                    hsv_color(hue, sat_reg, bright_reg, r, g, b);
                    if (32'(req.pixel_index) != (frame_cnt / 32'd3) % 32'(lit_reg))
                    begin
                        r /= 10; g /= 10; b /= 10;
                    end
                end
                lsepg_pkg::FX_SPARKLE:
                begin
                    hsv_color(hue, sat_reg, bright_reg, r, g, b);
                    if (req.random_word % 32'd20 != 0)
                    begin
                        r /= 8; g /= 8; b /= 8;
                    end
                end
                default: ;
            endcase
        end
        rsp.red = 8'(r);
        rsp.green = 8'(g);
        rsp.blue = 8'(b);
        rsp.last_pixel = (req.pixel_index == NUM_LEDS - 1);
        return rsp;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input int value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 9'(value);
        case (idx)
            lsepg_pkg::REG_BASE_HUE:   hue_reg = 9'(value);
            lsepg_pkg::REG_SATURATION: sat_reg = 8'(value);
            lsepg_pkg::REG_BRIGHTNESS: bright_reg = 8'(value);
            lsepg_pkg::REG_LIT_COUNT:  lit_reg = 6'(value);
            lsepg_pkg::REG_EFFECT:     fx_reg = 3'(value);
            lsepg_pkg::REG_ENABLE:     enable_reg = 1'(value);
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    // hold the beat until taken, then queue its expected colour
    task automatic send_pixel(input lsepg_pkg::pix_req_t req, input bit may_idle);
        lsepg_pkg::pix_rsp_t rsp;
        if (may_idle)
            while ($urandom_range(99) < 36)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        rsp = predict_pixel(req);
        pending_pixels.push_back(rsp);
        sent_count++;
    endtask

    // collect result beats
    always @(posedge clk)
    begin
        lsepg_pkg::pix_rsp_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
                report_mismatch("unexpected beat", 1, 0);
            else
            begin
                want = pending_pixels.pop_front();
                if (out_data.red !== want.red)
                    report_mismatch("red", out_data.red, want.red);
                if (out_data.green !== want.green)
                    report_mismatch("green", out_data.green, want.green);
                if (out_data.blue !== want.blue)
                    report_mismatch("blue", out_data.blue, want.blue);
                if (out_data.last_pixel !== want.last_pixel)
                    report_mismatch("last_pixel", out_data.last_pixel, want.last_pixel);
                checked_count++;
            end
        end
        out_ready <= quiet_out ? 1'b1 : ($urandom_range(99) >= 36);
    end

    function automatic lsepg_pkg::pix_req_t random_req();
        lsepg_pkg::pix_req_t req;
        int pick;
        pick = $urandom_range(99);
        req.pixel_index = (pick < 85) ? 6'($urandom_range(NUM_LEDS - 1)) : 6'($urandom);
        req.frame_start = ($urandom_range(3) == 0);
        req.random_word = ($urandom_range(3) == 0) ? 32'($urandom_range(200)) * 32'd20 : $urandom;
        return req;
    endfunction

    initial
    begin
        #20ms;
        $display("timeout");
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        stim_row_t rows[$];
        lsepg_pkg::pix_req_t req;
        lsepg_pkg::pix_rsp_t got;
        int        phase_no;
        int        n;

        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        quiet_out = 1'b0;
        error_count = 0;
        checked_count = 0;
        sent_count = 0;
        hue_reg = 9'd0; sat_reg = 8'd255; bright_reg = 8'd128;
        lit_reg = 6'd10; fx_reg = lsepg_pkg::FX_SOLID; enable_reg = 1'b1; frame_cnt = 32'd0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table; hue 0 full saturation gives (v,0,0) after reset
        rows = '{
            '{6'd0,  1'b0, 32'd0,          1'b1, '{8'd128, 8'd0, 8'd0, 1'b0}},
            '{6'd9,  1'b0, 32'hFFFFFFFF,   1'b1, '{8'd128, 8'd0, 8'd0, 1'b0}},
            '{6'd10, 1'b0, 32'd0,          1'b1, '{8'd0, 8'd0, 8'd0, 1'b0}},
            '{6'd59, 1'b1, 32'd5,          1'b1, '{8'd0, 8'd0, 8'd0, 1'b1}},
            '{6'd63, 1'b0, 32'hAAAA5555,   1'b1, '{8'd0, 8'd0, 8'd0, 1'b0}},
            '{6'd3,  1'b1, 32'h5555AAAA,   1'b0, '{8'd0, 8'd0, 8'd0, 1'b0}}
        };
        foreach (rows[i])
        begin
            req.pixel_index = rows[i].pixel_index;
            req.frame_start = rows[i].frame_start;
            req.random_word = rows[i].random_word;
            send_pixel(req, 1'b0);
            got = pending_pixels[pending_pixels.size() - 1];
            if (rows[i].has_expect && got != rows[i].expect_rsp)
                report_mismatch("table row", int'(got), int'(rows[i].expect_rsp));
        end
        wait_idle();

        // walk each effect over extreme and ordinary settings
        for (phase_no = 0; phase_no < 24; phase_no++)
        begin
            case (phase_no % 6)
                0: begin
                    write_reg(lsepg_pkg::REG_BASE_HUE, 359);
                    write_reg(lsepg_pkg::REG_SATURATION, 0);
                    write_reg(lsepg_pkg::REG_BRIGHTNESS, 255);
                    write_reg(lsepg_pkg::REG_LIT_COUNT, 60);
                end
                1: begin
                    write_reg(lsepg_pkg::REG_BASE_HUE, 511);
                    write_reg(lsepg_pkg::REG_SATURATION, 255);
                    write_reg(lsepg_pkg::REG_BRIGHTNESS, 0);
                    write_reg(lsepg_pkg::REG_LIT_COUNT, 1);
                end
                2: begin
                    write_reg(lsepg_pkg::REG_BASE_HUE, 360);
                    write_reg(lsepg_pkg::REG_LIT_COUNT, 0);
                end
                3: write_reg(lsepg_pkg::REG_ENABLE + 3'd1 + 3'($urandom_range(1)),
                             $urandom_range(511));
                default: begin
                    write_reg(lsepg_pkg::REG_BASE_HUE, $urandom_range(511));
                    write_reg(lsepg_pkg::REG_SATURATION, $urandom_range(255));
                    write_reg(lsepg_pkg::REG_BRIGHTNESS, $urandom_range(255));
                    write_reg(lsepg_pkg::REG_LIT_COUNT, $urandom_range(63));
                end
            endcase
            write_reg(lsepg_pkg::REG_EFFECT, (phase_no < 20) ? phase_no % 5 : $urandom_range(7));
            write_reg(lsepg_pkg::REG_ENABLE, (phase_no % 7 == 6) ? 0 : 1);
            // long stretch with no idling on either side
            quiet_out = (phase_no == 10);
            for (n = 0; n < 50; n++)
            begin
                send_pixel(random_req(), phase_no != 10);
                // drain everything before carrying on
                if (n == 25 && phase_no == 5)
                begin
                    in_valid <= 1'b0;
                    while (pending_pixels.size() != 0)
                        @(posedge clk);
                end
            end
            quiet_out = 1'b0;
            wait_idle();
        end

        $display("sent %0d pixel requests over 24 register settings, all five effects", sent_count);
        $display("checked %0d colour beats", checked_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
